@@ rtl/tracking_wheel_arc_odometry_assert.svh @@
// Assertion helpers shared by the odometry RTL.
// Both macros sample on clk and are disabled while rst is high.
`ifndef TRACKING_WHEEL_ARC_ODOMETRY_ASSERT_SVH
`define TRACKING_WHEEL_ARC_ODOMETRY_ASSERT_SVH

// Same-cycle implication.
`define TWAO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define TWAO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/twao_pkg.sv @@
`timescale 1ns / 1ps
package twao_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  // Register indexes on the configuration channel
  localparam logic [2:0] REG_PAR_OFF  = 3'd0;
  localparam logic [2:0] REG_PERP_OFF = 3'd1;
  localparam logic [2:0] REG_PAR_IPD  = 3'd2;
  localparam logic [2:0] REG_PERP_IPD = 3'd3;
  localparam logic [2:0] REG_IMU1_SC  = 3'd4;
  localparam logic [2:0] REG_IMU2_SC  = 3'd5;
  localparam logic [2:0] REG_MIRROR   = 3'd6;
  localparam logic [2:0] REG_HEAD_OFF = 3'd7;

  // Sample commands
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  // Fixed-point constants
  localparam logic signed [63:0] DEG2RAD_Q32  = 64'sd74961321;
  localparam logic signed [63:0] RAD_ROUND    = 64'sd2147483648;
  localparam logic signed [63:0] CNT_DIVISOR  = 64'sd100;
  localparam logic signed [63:0] CNT_ROUND    = 64'sd50;
  localparam logic signed [33:0] TWO_PI_Q29   = 34'sd3373259426;
  localparam logic signed [33:0] PI_Q29       = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q29  = 34'sd843314857;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [48:0] DELTA_LIMIT  = 49'sd549755813887;

  // Request from the sequencer to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // Arctangent of 2^-i in Q29
  function automatic logic signed [33:0] atan_q29(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510843;
      5'd5:  v = 34'sd16771758;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      5'd24: v = 34'sd32;
      5'd25: v = 34'sd16;
      5'd26: v = 34'sd8;
      5'd27: v = 34'sd4;
      5'd28: v = 34'sd2;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/twao_cfg_if.sv @@
`timescale 1ns / 1ps
interface twao_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/twao_sample_if.sv @@
`timescale 1ns / 1ps
interface twao_sample_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] parallel_count;
  logic signed [31:0] perpendicular_count;
  logic signed [31:0] first_imu_heading;
  logic signed [31:0] second_imu_heading;
  logic               second_imu_present;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  modport source(output valid, output command, output parallel_count,
                 output perpendicular_count, output first_imu_heading,
                 output second_imu_heading, output second_imu_present,
                 output start_x, output start_y, input ready);
  modport sink(input valid, input command, input parallel_count,
               input perpendicular_count, input first_imu_heading,
               input second_imu_heading, input second_imu_present,
               input start_x, input start_y, output ready);
endinterface

@@ rtl/twao_result_if.sv @@
`timescale 1ns / 1ps
interface twao_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] field_heading;
  modport source(output valid, output position_x, output position_y,
                 output field_heading, input ready);
  modport sink(input valid, input position_x, input position_y,
               input field_heading, output ready);
endinterface

@@ rtl/twao_muldiv.sv @@
`timescale 1ns / 1ps
`include "tracking_wheel_arc_odometry_assert.svh"
// Shared sign-magnitude unit: shift-add multiply, one multiplier bit per
// cycle, or restoring divide, one quotient bit per cycle. Division truncates
// toward zero; remainder takes the dividend sign.
module twao_muldiv (
  input  logic                clk,
  input  logic                rst,
  input  twao_pkg::md_req_t   req,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic                done,
  output logic signed [63:0]  res,
  output logic signed [63:0]  rem
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_RUN  = 2'd1;
  localparam logic [1:0] U_FIN  = 2'd2;

  logic [1:0]  ust;
  logic        is_div;
  logic [5:0]  cnt;
  logic [63:0] sh;
  logic [31:0] mb;
  logic [63:0] acc;
  logic [32:0] r;
  logic        neg_q;
  logic        neg_r;
  logic [63:0] a_mag;
  logic [63:0] b_mag;
  logic [32:0] r_try;
  logic        last;

  assign a_mag = a[63] ? 64'(-a) : 64'(a);
  assign b_mag = b[63] ? 64'(-b) : 64'(b);
  assign r_try = {r[31:0], sh[63]};
  assign last  = is_div ? (cnt == 6'd63) : (cnt == 6'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      ust  <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ust)
        U_IDLE: begin
          // load magnitudes and signs
          if (req.start) begin
            is_div <= req.is_div;
            sh     <= a_mag;
            mb     <= b_mag[31:0];
            acc    <= 64'd0;
            r      <= 33'd0;
            cnt    <= 6'd0;
            neg_q  <= a[63] ^ b[63];
            neg_r  <= a[63];
            ust    <= U_RUN;
          end
        end
        U_RUN: begin
          if (is_div) begin
            // shift one dividend bit in, try to subtract
            if (r_try >= {1'b0, mb}) begin
              r  <= r_try - {1'b0, mb};
              sh <= {sh[62:0], 1'b1};
            end else begin
              r  <= r_try;
              sh <= {sh[62:0], 1'b0};
            end
          end else begin
            // add shifted multiplicand for each set multiplier bit
            if (mb[0]) acc <= acc + sh;
            sh <= {sh[62:0], 1'b0};
            mb <= {1'b0, mb[31:1]};
          end
          cnt <= cnt + 6'd1;
          if (last) ust <= U_FIN;
        end
        U_FIN: begin
          // apply signs
          if (is_div) res <= neg_q ? -$signed(sh) : $signed(sh);
          else res <= neg_q ? -$signed(acc) : $signed(acc);
          rem  <= neg_r ? -$signed({31'd0, r}) : $signed({31'd0, r});
          done <= 1'b1;
          ust  <= U_IDLE;
        end
        default: ust <= U_IDLE;
      endcase
    end
  end

  `TWAO_ASSERT_NEXT(a_done_pulse, done, !done)
  `TWAO_ASSERT_NEXT(a_fin_done, ust == U_FIN, done)
  `TWAO_ASSERT_NEXT(a_start_runs, req.start && ust == U_IDLE, ust == U_RUN)

endmodule

@@ rtl/tracking_wheel_arc_odometry.sv @@
`timescale 1ns / 1ps
`include "tracking_wheel_arc_odometry_assert.svh"
// Channel  Modport  Payload
// cfg      sink     index[2:0], data[31:0]; ready always high
// sample   sink     command, two wheel counts, two IMU headings, start x/y
// result   source   position_x, position_y, field_heading
//
// One sample at a time; every multiply and divide runs on one shared
// multiply/divide unit.
// An update with an arc step takes a second angle reduction and CORDIC
// pass, and four products each followed by a divide.
// Reset (rst, synchronous) restores the register defaults and zero state.
// A held result stalls the block only at its final write-back cycle.
module tracking_wheel_arc_odometry #(
  parameter int CORDIC_STEPS = twao_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  twao_cfg_if.sink       cfg,
  twao_sample_if.sink    sample,
  twao_result_if.source  result
);

  localparam int IW = $clog2(CORDIC_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_TRIG  = 3'd3;
  localparam logic [2:0] S_TFIN  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [4:0] P_IMU1 = 5'd0;
  localparam logic [4:0] P_IMU2 = 5'd1;
  localparam logic [4:0] P_ARAD = 5'd2;
  localparam logic [4:0] P_RRAD = 5'd3;
  localparam logic [4:0] P_CNTP = 5'd4;
  localparam logic [4:0] P_OFFP = 5'd5;
  localparam logic [4:0] P_CNTQ = 5'd6;
  localparam logic [4:0] P_OFFQ = 5'd7;
  localparam logic [4:0] P_DP   = 5'd8;
  localparam logic [4:0] P_DQ   = 5'd9;
  localparam logic [4:0] P_MODA = 5'd10;
  localparam logic [4:0] P_MODL = 5'd11;
  localparam logic [4:0] P_S1   = 5'd12;
  localparam logic [4:0] P_S2   = 5'd13;
  localparam logic [4:0] P_S3   = 5'd14;
  localparam logic [4:0] P_S4   = 5'd15;
  localparam logic [4:0] P_A1   = 5'd16;
  localparam logic [4:0] P_A2   = 5'd17;
  localparam logic [4:0] P_A3   = 5'd18;
  localparam logic [4:0] P_A4   = 5'd19;
  localparam logic [4:0] P_A5   = 5'd20;
  localparam logic [4:0] P_A6   = 5'd21;
  localparam logic [4:0] P_A7   = 5'd22;
  localparam logic [4:0] P_A8   = 5'd23;

  // configuration registers
  logic signed [23:0] off_p, off_q;
  logic [23:0]        ipd_p, ipd_q;
  logic [17:0]        sc1, sc2;
  logic               mirror;
  logic signed [31:0] head_off;

  // captured sample
  logic               cmd;
  logic signed [31:0] cnt_p, cnt_q, h1, h2, sx, sy;
  logic               h2_en;

  // odometry state
  logic signed [31:0] pos_x, pos_y, last_h;
  logic signed [47:0] last_p, last_q;

  // per-sample temporaries
  logic [2:0]         st;
  logic [4:0]         step;
  logic signed [33:0] imu1;
  logic signed [31:0] raw_q, field_q, a_rad, r_rad, dp, dq;
  logic signed [47:0] cp, tp, tq;
  logic signed [31:0] c, s, cl, sl;
  logic signed [63:0] acc;
  logic signed [51:0] tx, ty;

  // CORDIC
  logic signed [33:0] cx, cy, cz;
  logic               cneg, trig_last;
  logic [IW-1:0]      ci;

  // result register
  logic               out_valid;
  logic signed [31:0] out_x, out_y, out_h;

  // shared unit
  twao_pkg::md_req_t  md_req;
  logic signed [63:0] opa, opb, md_res, md_rem;
  logic               md_done;

  // datapath helpers
  logic signed [33:0] imu2_c;
  logic signed [34:0] sum35, half;
  logic signed [35:0] mir;
  logic signed [31:0] raw_c, field_c;
  logic signed [63:0] np, nq;
  logic signed [48:0] dpr, dqr, dpc, dqc;
  logic signed [32:0] dth, dc, ds;
  logic signed [33:0] m, r0, r1, z0;
  logic               zneg;
  logic signed [33:0] fx, fy;
  logic signed [31:0] cos_c, sin_c;
  logic               cnt_adj;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (st == S_IDLE);
  assign result.valid = out_valid;
  assign result.position_x    = out_x;
  assign result.position_y    = out_y;
  assign result.field_heading = out_h;

  // heading arithmetic
  assign imu2_c  = h2_en ? 34'(md_res >>> 16) : imu1;
  assign sum35   = 35'(imu1) + 35'(imu2_c);
  assign half    = sum35 >>> 1;
  assign mir     = mirror ? -36'(half) : 36'(half);
  assign raw_c   = twao_pkg::sat32(64'(mir));
  assign field_c = twao_pkg::sat32(64'(raw_q) + 64'(head_off));

  // counts scaled to Q16 with rounding bias
  assign np = {{16{cnt_p[31]}}, cnt_p, 16'd0} + twao_pkg::CNT_ROUND;
  assign nq = {{16{cnt_q[31]}}, cnt_q, 16'd0} + twao_pkg::CNT_ROUND;
  assign cnt_adj = (md_rem != 64'sd0) && (step == P_CNTP ? np < 0 : nq < 0);

  // clamped travel differences
  assign dpr = 49'(tp) - 49'(last_p);
  assign dqr = 49'(tq) - 49'(last_q);
  assign dpc = (dpr > twao_pkg::DELTA_LIMIT) ? twao_pkg::DELTA_LIMIT :
               (dpr < -twao_pkg::DELTA_LIMIT) ? -twao_pkg::DELTA_LIMIT : dpr;
  assign dqc = (dqr > twao_pkg::DELTA_LIMIT) ? twao_pkg::DELTA_LIMIT :
               (dqr < -twao_pkg::DELTA_LIMIT) ? -twao_pkg::DELTA_LIMIT : dqr;

  assign dth = 33'(a_rad) - 33'(last_h);
  assign dc  = 33'(c) - 33'(cl);
  assign ds  = 33'(s) - 33'(sl);

  // angle reduction to [-pi/2, pi/2] from the remainder
  assign m  = 34'(md_rem);
  assign r0 = (m < 0) ? m + twao_pkg::TWO_PI_Q29 : m;
  assign r1 = (r0 >= twao_pkg::PI_Q29) ? r0 - twao_pkg::TWO_PI_Q29 : r0;
  always_comb begin
    if (r1 > twao_pkg::HALF_PI_Q29) begin
      z0   = r1 - twao_pkg::PI_Q29;
      zneg = 1'b1;
    end else if (r1 < -twao_pkg::HALF_PI_Q29) begin
      z0   = r1 + twao_pkg::PI_Q29;
      zneg = 1'b1;
    end else begin
      z0   = r1;
      zneg = 1'b0;
    end
  end

  // CORDIC output fold and clamp
  assign fx = cneg ? -cx : cx;
  assign fy = cneg ? -cy : cy;
  assign cos_c = (fx > twao_pkg::ONE_Q30) ? 32'(twao_pkg::ONE_Q30) :
                 (fx < -twao_pkg::ONE_Q30) ? 32'(-twao_pkg::ONE_Q30) : 32'(fx);
  assign sin_c = (fy > twao_pkg::ONE_Q30) ? 32'(twao_pkg::ONE_Q30) :
                 (fy < -twao_pkg::ONE_Q30) ? 32'(-twao_pkg::ONE_Q30) : 32'(fy);

  // operand select per step
  always_comb begin
    md_req.start  = (st == S_ISSUE);
    md_req.is_div = 1'b0;
    opa = 64'sd0;
    opb = 64'sd0;
    case (step)
      P_IMU1: begin opa = 64'(h1); opb = {46'd0, sc1}; end
      P_IMU2: begin opa = 64'(h2); opb = {46'd0, sc2}; end
      P_ARAD: begin opa = 64'(field_c); opb = twao_pkg::DEG2RAD_Q32; end
      P_RRAD: begin opa = 64'(raw_q); opb = twao_pkg::DEG2RAD_Q32; end
      P_CNTP: begin md_req.is_div = 1'b1; opa = np; opb = twao_pkg::CNT_DIVISOR; end
      P_OFFP: begin opa = 64'(r_rad); opb = 64'(off_p); end
      P_CNTQ: begin md_req.is_div = 1'b1; opa = nq; opb = twao_pkg::CNT_DIVISOR; end
      P_OFFQ: begin opa = 64'(r_rad); opb = 64'(off_q); end
      P_DP:   begin opa = 64'(dpc); opb = {40'd0, ipd_p}; end
      P_DQ:   begin opa = 64'(dqc); opb = {40'd0, ipd_q}; end
      P_MODA: begin
        md_req.is_div = 1'b1;
        opa = {{19{a_rad[31]}}, a_rad, 13'd0};
        opb = 64'(twao_pkg::TWO_PI_Q29);
      end
      P_MODL: begin
        md_req.is_div = 1'b1;
        opa = {{19{last_h[31]}}, last_h, 13'd0};
        opb = 64'(twao_pkg::TWO_PI_Q29);
      end
      P_S1:   begin opa = 64'(c); opb = 64'(dp); end
      P_S2:   begin opa = 64'(s); opb = 64'(dq); end
      P_S3:   begin opa = 64'(c); opb = 64'(dq); end
      P_S4:   begin opa = 64'(s); opb = 64'(dp); end
      P_A1:   begin opa = 64'(dp); opb = 64'(dc); end
      P_A3:   begin opa = 64'(dq); opb = 64'(ds); end
      P_A5:   begin opa = 64'(dp); opb = 64'(-ds); end
      P_A7:   begin opa = 64'(dq); opb = 64'(dc); end
      P_A2, P_A4, P_A6, P_A8: begin
        md_req.is_div = 1'b1;
        opa = md_res;
        opb = 64'(dth);
      end
      default: begin opa = 64'sd0; opb = 64'sd0; end
    endcase
  end

  twao_muldiv u_md (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .a    (opa),
    .b    (opb),
    .done (md_done),
    .res  (md_res),
    .rem  (md_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      off_p    <= '0;
      off_q    <= '0;
      ipd_p    <= '0;
      ipd_q    <= '0;
      sc1      <= 18'd65536;
      sc2      <= 18'd65536;
      mirror   <= 1'b0;
      head_off <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        twao_pkg::REG_PAR_OFF:  off_p    <= cfg.data[23:0];
        twao_pkg::REG_PERP_OFF: off_q    <= cfg.data[23:0];
        twao_pkg::REG_PAR_IPD:  ipd_p    <= cfg.data[23:0];
        twao_pkg::REG_PERP_IPD: ipd_q    <= cfg.data[23:0];
        twao_pkg::REG_IMU1_SC:  sc1      <= cfg.data[17:0];
        twao_pkg::REG_IMU2_SC:  sc2      <= cfg.data[17:0];
        twao_pkg::REG_MIRROR:   mirror   <= cfg.data[0];
        twao_pkg::REG_HEAD_OFF: head_off <= cfg.data;
        default: mirror <= mirror;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      step      <= P_IMU1;
      out_valid <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
      last_p    <= '0;
      last_q    <= '0;
      last_h    <= '0;
    end else begin
      // drop the result once transferred
      if (result.valid && result.ready) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (sample.valid) begin
            cmd   <= sample.command;
            cnt_p <= sample.parallel_count;
            cnt_q <= sample.perpendicular_count;
            h1    <= sample.first_imu_heading;
            h2    <= sample.second_imu_heading;
            h2_en <= sample.second_imu_present;
            sx    <= sample.start_x;
            sy    <= sample.start_y;
            step  <= P_IMU1;
            st    <= S_ISSUE;
          end
        end
        S_ISSUE: st <= S_WAIT;
        S_WAIT: begin
          if (md_done) begin
            st <= S_ISSUE;
            case (step)
              P_IMU1: begin imu1 <= 34'(md_res >>> 16); step <= P_IMU2; end
              P_IMU2: begin raw_q <= raw_c; step <= P_ARAD; end
              P_ARAD: begin
                a_rad   <= 32'((md_res + twao_pkg::RAD_ROUND) >>> 32);
                field_q <= field_c;
                step    <= P_RRAD;
              end
              P_RRAD: begin
                r_rad <= 32'((md_res + twao_pkg::RAD_ROUND) >>> 32);
                step  <= P_CNTP;
              end
              P_CNTP: begin
                cp   <= 48'(cnt_adj ? md_res - 64'sd1 : md_res);
                step <= P_OFFP;
              end
              P_OFFP: begin
                tp   <= 48'(64'(cp) - (md_res >>> 16));
                step <= P_CNTQ;
              end
              P_CNTQ: begin
                cp   <= 48'(cnt_adj ? md_res - 64'sd1 : md_res);
                step <= P_OFFQ;
              end
              P_OFFQ: begin
                tq <= 48'(64'(cp) - (md_res >>> 16));
                if (cmd == twao_pkg::CMD_START) st <= S_OUT;
                else step <= P_DP;
              end
              P_DP: begin dp <= twao_pkg::sat32(md_res >>> 24); step <= P_DQ; end
              P_DQ: begin dq <= twao_pkg::sat32(md_res >>> 24); step <= P_MODA; end
              P_MODA, P_MODL: begin
                // start rotation from the reduced angle
                cx        <= twao_pkg::CORDIC_GAIN;
                cy        <= 34'sd0;
                cz        <= z0;
                cneg      <= zneg;
                ci        <= '0;
                trig_last <= (step == P_MODL);
                st        <= S_TRIG;
              end
              P_S1: begin acc <= md_res; step <= P_S2; end
              P_S2: begin tx <= 52'((acc + md_res) >>> 30); step <= P_S3; end
              P_S3: begin acc <= md_res; step <= P_S4; end
              P_S4: begin ty <= 52'((acc - md_res) >>> 30); st <= S_OUT; end
              P_A2: begin tx <= 52'(md_res >>> 14); step <= P_A3; end
              P_A4: begin tx <= tx + 52'(md_res >>> 14); step <= P_A5; end
              P_A6: begin ty <= 52'(md_res >>> 14); step <= P_A7; end
              P_A8: begin ty <= ty + 52'(md_res >>> 14); st <= S_OUT; end
              default: step <= step + 5'd1;
            endcase
          end
        end
        S_TRIG: begin
          // one micro-rotation per cycle
          if (cz >= 0) begin
            cx <= cx - (cy >>> ci);
            cy <= cy + (cx >>> ci);
            cz <= cz - twao_pkg::atan_q29(5'(ci));
          end else begin
            cx <= cx + (cy >>> ci);
            cy <= cy - (cx >>> ci);
            cz <= cz + twao_pkg::atan_q29(5'(ci));
          end
          if (ci == IW'(CORDIC_STEPS - 1)) st <= S_TFIN;
          else ci <= ci + 1'b1;
        end
        S_TFIN: begin
          st <= S_ISSUE;
          if (!trig_last) begin
            c    <= cos_c;
            s    <= sin_c;
            step <= (dth == 33'sd0) ? P_S1 : P_MODL;
          end else begin
            cl   <= cos_c;
            sl   <= sin_c;
            step <= P_A1;
          end
        end
        S_OUT: begin
          // write back once the result register is free
          if (!out_valid || result.ready) begin
            if (cmd == twao_pkg::CMD_START) begin
              pos_x <= sx;
              pos_y <= sy;
              out_x <= sx;
              out_y <= sy;
            end else begin
              pos_x <= twao_pkg::sat32(64'(pos_x) + 64'(tx));
              pos_y <= twao_pkg::sat32(64'(pos_y) + 64'(ty));
              out_x <= twao_pkg::sat32(64'(pos_x) + 64'(tx));
              out_y <= twao_pkg::sat32(64'(pos_y) + 64'(ty));
            end
            out_h     <= field_q;
            last_p    <= tp;
            last_q    <= tq;
            last_h    <= a_rad;
            out_valid <= 1'b1;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `TWAO_ASSERT_IMP(a_done_while_wait, md_done, st == S_WAIT)
  `TWAO_ASSERT_NEXT(a_accept_issues, sample.valid && sample.ready,
                    st == S_ISSUE && step == P_IMU1)
  `TWAO_ASSERT_NEXT(a_out_loads, st == S_OUT && (!out_valid || result.ready),
                    out_valid && st == S_IDLE)

endmodule

@@ dv/tracking_wheel_arc_odometry_test.sv @@
`timescale 1ns / 1ps
module tracking_wheel_arc_odometry_test;
  import twao_pkg::*;

  typedef struct {
    logic        command;
    int          par_count;
    int          perp_count;
    int          imu1;
    int          imu2;
    logic        imu2_on;
    int          sx;
    int          sy;
  } odo_sample_t;

  typedef struct {
    int px;
    int py;
    int hd;
  } odo_pose_t;

  localparam int  CYCLE_LIMIT = 8000000;
  localparam int  HOLD_CYCLES = 4000;
  localparam longint TWO_PI_Q29_L  = 64'sd3373259426;
  localparam longint PI_Q29_L      = 64'sd1686629713;
  localparam longint HALF_PI_Q29_L = 64'sd843314857;
  localparam longint ONE_Q30_L     = 64'sd1073741824;
  localparam longint TRAVEL_CLAMP  = 64'sd549755813887;

  // Fixed-point odometry tracker and queue of expected poses
  class pose_tracker;
    longint    par_off, perp_off, par_ipd, perp_ipd, sc1, sc2, mirror, head_off;
    longint    px, py, last_par, last_perp, last_rad;
    longint    atan_tab[32];
    odo_pose_t pending_poses[$];
    int        errors;

    function new();
      atan_tab = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
                   8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072,
                   65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128,
                   64, 32, 16, 8, 4, 2, 1, 1, 0};
      par_off = 0; perp_off = 0; par_ipd = 0; perp_ipd = 0;
      sc1 = 65536; sc2 = 65536; mirror = 0; head_off = 0;
      px = 0; py = 0; last_par = 0; last_perp = 0; last_rad = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_PAR_OFF:  par_off  = longint'($signed(d[23:0]));
        REG_PERP_OFF: perp_off = longint'($signed(d[23:0]));
        REG_PAR_IPD:  par_ipd  = longint'({40'd0, d[23:0]});
        REG_PERP_IPD: perp_ipd = longint'({40'd0, d[23:0]});
        REG_IMU1_SC:  sc1      = longint'({46'd0, d[17:0]});
        REG_IMU2_SC:  sc2      = longint'({46'd0, d[17:0]});
        REG_MIRROR:   mirror   = longint'({63'd0, d[0]});
        default:      head_off = longint'($signed(d));
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint deg_to_rad(longint deg);
      return (deg * 64'sd74961321 + 64'sd2147483648) >>> 32;
    endfunction

    // Rotate the unit vector by CORDIC after folding the angle into +-pi/2
    function void sincos(longint rad, output longint c, output longint s);
      longint r, x, y, nx;
      bit     flip;
      r = (rad * 8192) % TWO_PI_Q29_L;
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      if (r < 0) r += TWO_PI_Q29_L;
      if (r >= PI_Q29_L) r -= TWO_PI_Q29_L;
      if (r > HALF_PI_Q29_L) begin
        r -= PI_Q29_L; flip = 1;
      end else if (r < -HALF_PI_Q29_L) begin
        r += PI_Q29_L; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
        if (r >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          r -= atan_tab[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          r += atan_tab[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      if (x > ONE_Q30_L) x = ONE_Q30_L;
      if (x < -ONE_Q30_L) x = -ONE_Q30_L;
      if (y > ONE_Q30_L) y = ONE_Q30_L;
      if (y < -ONE_Q30_L) y = -ONE_Q30_L;
      c = x;
      s = y;
    endfunction

    function longint wheel_step(longint now, longint prev, longint ipd);
      longint d;
      d = now - prev;
      if (d > TRAVEL_CLAMP) d = TRAVEL_CLAMP;
      if (d < -TRAVEL_CLAMP) d = -TRAVEL_CLAMP;
      return clamp32((d * ipd) >>> 24);
    endfunction

    function longint arc_part(longint delta, longint tdiff, longint dth);
      return ((delta * tdiff) / dth) >>> 14;
    endfunction

    // Advance the pose for one accepted sample and queue the result
    function void note_sample(odo_sample_t s);
      longint    a1, a2, raw, field, a_rad, r_rad, tp, tq;
      longint    dp, dq, dth, c, sn, cl, sl, tx, ty;
      odo_pose_t p;
      a1 = (longint'(s.imu1) * sc1) >>> 16;
      a2 = s.imu2_on ? ((longint'(s.imu2) * sc2) >>> 16) : a1;
      raw = (a1 + a2) >>> 1;
      if (mirror != 0) raw = -raw;
      raw = clamp32(raw);
      field = clamp32(raw + head_off);
      a_rad = deg_to_rad(field);
      r_rad = deg_to_rad(raw);
      tp = floor_div(longint'(s.par_count) * 65536 + 50, 100) - ((r_rad * par_off) >>> 16);
      tq = floor_div(longint'(s.perp_count) * 65536 + 50, 100) - ((r_rad * perp_off) >>> 16);
      if (s.command == CMD_START) begin
        px = s.sx;
        py = s.sy;
      end else begin
        dp = wheel_step(tp, last_par, par_ipd);
        dq = wheel_step(tq, last_perp, perp_ipd);
        dth = a_rad - last_rad;
        sincos(a_rad, c, sn);
        if (dth == 0) begin
          tx = (c * dp + sn * dq) >>> 30;
          ty = (c * dq - sn * dp) >>> 30;
        end else begin
          sincos(last_rad, cl, sl);
          tx = arc_part(dp, c - cl, dth) + arc_part(dq, sn - sl, dth);
          ty = arc_part(dp, sl - sn, dth) + arc_part(dq, c - cl, dth);
        end
        px = clamp32(px + tx);
        py = clamp32(py + ty);
      end
      last_par = tp;
      last_perp = tq;
      last_rad = a_rad;
      p.px = int'(px);
      p.py = int'(py);
      p.hd = int'(field);
      pending_poses.push_back(p);
    endfunction

    function void check_pose(int ax, int ay, int ah);
      odo_pose_t e;
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d heading=%0d", $time, ax, ay, ah);
        errors++;
        return;
      end
      e = pending_poses.pop_front();
      if (ax !== e.px) begin
        $display("%0t: position_x expected %0d actual %0d", $time, e.px, ax);
        errors++;
      end
      if (ay !== e.py) begin
        $display("%0t: position_y expected %0d actual %0d", $time, e.py, ay);
        errors++;
      end
      if (ah !== e.hd) begin
        $display("%0t: field_heading expected %0d actual %0d", $time, e.hd, ah);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  twao_cfg_if    cfg_bus();
  twao_sample_if sample_bus();
  twao_result_if result_bus();

  tracking_wheel_arc_odometry i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .sample (sample_bus),
    .result (result_bus)
  );

  pose_tracker tracker;
  bit          hold_request;
  bit          quiet_phase;
  int          cycle_count;

  // Track the encoder counts and headings along a plausible path
  int          cur_par, cur_perp, cur_h1, cur_h2;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tracking_wheel_arc_odometry verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 25);
    return $urandom_range(60, 300);
  endfunction

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    int g;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_bus.ready <= 1'b0;
        hold_request = 0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        result_bus.ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          result_bus.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      tracker.check_pose(result_bus.position_x, result_bus.position_y,
                         result_bus.field_heading);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    tracker.write_reg(idx, d);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(odo_sample_t s);
    int g;
    sample_bus.valid               <= 1'b1;
    sample_bus.command             <= s.command;
    sample_bus.parallel_count      <= s.par_count;
    sample_bus.perpendicular_count <= s.perp_count;
    sample_bus.first_imu_heading   <= s.imu1;
    sample_bus.second_imu_heading  <= s.imu2;
    sample_bus.second_imu_present  <= s.imu2_on;
    sample_bus.start_x             <= s.sx;
    sample_bus.start_y             <= s.sy;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    tracker.note_sample(s);
    g = pick_gap();
    if (g > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_poses.size() != 0) @(posedge clk);
  endtask

  function automatic odo_sample_t make_sample(logic cmd, int pc, int qc, int h1, int h2,
                                               logic on, int sx, int sy);
    odo_sample_t s;
    s.command = cmd; s.par_count = pc; s.perp_count = qc;
    s.imu1 = h1; s.imu2 = h2; s.imu2_on = on; s.sx = sx; s.sy = sy;
    return s;
  endfunction

  function automatic odo_sample_t noise_sample();
    return make_sample($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 1), $urandom, $urandom);
  endfunction

  // Mostly small encoder and heading steps; some repeat the heading exactly
  function automatic odo_sample_t path_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      cur_par = $urandom; cur_perp = $urandom;
      return make_sample(CMD_START, cur_par, cur_perp, cur_h1, cur_h2,
                         $urandom_range(0, 1), $urandom, $urandom);
    end
    if (r < 12) return noise_sample();
    cur_par  += $signed($urandom_range(0, 40000)) - 20000;
    cur_perp += $signed($urandom_range(0, 40000)) - 20000;
    if ($urandom_range(0, 2) != 0) begin
      cur_h1 += $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      cur_h2 = cur_h1 + $signed($urandom_range(0, 4096)) - 2048;
    end
    return make_sample(CMD_UPDATE, cur_par, cur_perp, cur_h1, cur_h2,
                       $urandom_range(0, 3) != 0, $urandom, $urandom);
  endfunction

  task automatic load_config(int mode);
    logic [31:0] v [8];
    for (int i = 0; i < 8; i++) v[i] = $urandom;
    if (mode == 0) begin
      v = '{32'h007fffff, 32'h007fffff, 32'h00ffffff, 32'h00ffffff,
            32'h0003ffff, 32'h0003ffff, 32'h1, 32'h7fffffff};
    end else if (mode == 1) begin
      v = '{32'h00800000, 32'h00800000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000};
    end else if (mode > 2) begin
      // realistic robot geometry; the IPD and mirror registers keep random values
      v[REG_PAR_OFF]  = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      v[REG_PERP_OFF] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      v[REG_IMU1_SC]  = $urandom_range(60000, 70000);
      v[REG_IMU2_SC]  = $urandom_range(60000, 70000);
      v[REG_HEAD_OFF] = $signed($urandom_range(0, 360 << 16)) - (180 << 16);
    end
    for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
  endtask

  initial begin
    odo_sample_t s;
    tracker = new();
    hold_request = 0;
    quiet_phase = 0;
    cycle_count = 0;
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_PAR_OFF;
    cfg_bus.data = '0;
    sample_bus.valid = 1'b0;
    sample_bus.command = CMD_UPDATE;
    sample_bus.parallel_count = 0;
    sample_bus.perpendicular_count = 0;
    sample_bus.first_imu_heading = 0;
    sample_bus.second_imu_heading = 0;
    sample_bus.second_imu_present = 1'b0;
    sample_bus.start_x = 0;
    sample_bus.start_y = 0;
    cur_par = 0; cur_perp = 0; cur_h1 = 0; cur_h2 = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset defaults, both extreme settings, then a realistic geometry
    send_sample(make_sample(CMD_UPDATE, 1000, -1000, 0, 0, 1'b0, 0, 0));
    send_sample(make_sample(CMD_START, 0, 0, 5 << 16, 5 << 16, 1'b1, 100 << 16, -(7 << 16)));
    wait_idle();
    load_config(0);
    send_sample(make_sample(CMD_START, 0, 0, 0, 0, 1'b1, 32'sh7fffffff, 32'sh80000000));
    send_sample(make_sample(CMD_UPDATE, 32'sh7fffffff, 32'sh80000000, 0, 0, 1'b1, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 32'sh7fffffff, 32'sh80000000, 0, 0, 1'b1, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 32'sh80000000, 32'sh7fffffff,
                            32'sh7fffffff, 32'sh7fffffff, 1'b1, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 32'sh7fffffff, 32'sh7fffffff,
                            32'sh80000000, 32'sh80000000, 1'b0, 0, 0));
    send_sample(make_sample(CMD_UPDATE, -1, 1, 32'sh80000000, 32'sh7fffffff, 1'b1, -1, -1));
    send_sample(make_sample(CMD_START, -1, -1, -1, -1, 1'b0, -1, -1));
    wait_idle();
    load_config(1);
    send_sample(make_sample(CMD_UPDATE, 32'sh80000000, 32'sh80000000,
                            32'sh80000000, 32'sh80000000, 1'b1, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 32'sh7fffffff, 32'sh7fffffff,
                            32'sh7fffffff, 32'sh7fffffff, 1'b0, 0, 0));
    wait_idle();
    load_config(3);
    send_sample(make_sample(CMD_START, 0, 0, 90 << 16, 90 << 16, 1'b1, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 36000, 0, 90 << 16, 90 << 16, 1'b1, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 72000, 9000, 180 << 16, 180 << 16, 1'b1, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 90000, 9000, 270 << 16, 0, 1'b0, 0, 0));
    send_sample(make_sample(CMD_UPDATE, 90000, 9000, -(30 << 16), -(30 << 16), 1'b1, 0, 0));

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      load_config(ph == 0 ? 0 : (ph == 1 ? 1 : 2 + ph % 4));
      quiet_phase = (ph == 5);
      cur_par = $urandom; cur_perp = $urandom; cur_h1 = $urandom_range(0, 1 << 26);
      cur_h2 = cur_h1;
      send_sample(make_sample(CMD_START, cur_par, cur_perp, cur_h1, cur_h2, 1'b1,
                              $urandom, $urandom));
      if (ph == 2) hold_request = 1;
      for (int n = 0; n < 185; n++) begin
        s = path_sample();
        send_sample(s);
      end
    end
    quiet_phase = 0;

    wait_idle();
    repeat (1500) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_poses.size() == 0)
      $display("tracking_wheel_arc_odometry verification clean");
    else
      $display("tracking_wheel_arc_odometry verification failed");
    $finish;
  end

endmodule

@@ tracking_wheel_arc_odometry.f @@
+incdir+rtl
rtl/twao_pkg.sv
rtl/twao_cfg_if.sv
rtl/twao_sample_if.sv
rtl/twao_result_if.sv
rtl/twao_muldiv.sv
rtl/tracking_wheel_arc_odometry.sv
dv/tracking_wheel_arc_odometry_test.sv
